// ===== sv/assert_macros.svh =====
// Assertion macros used by lstm_cell_forward_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check, live through reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/lcf_pkg.sv =====
// Constants, types and lookup table for the LSTM cell update pipeline.
package lcf_pkg;

    localparam int CELL_COUNT = 256;
    localparam int FRAC_BITS  = 12;

    localparam int IDX_W   = 8;
    localparam int DATA_W  = 16;
    localparam int HID_W   = 14;
    localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam int ACT_W      = FRAC_BITS + 2;
    localparam int MAG_W      = DATA_W + 1;
    localparam int Q16_W      = 17;
    localparam int S_W        = Q16_W + 1;
    localparam int LOG_SHIFT  = FRAC_BITS - 1;
    localparam int TANH_SHIFT = FRAC_BITS - 2;
    localparam int FRAC_W     = LOG_SHIFT;
    localparam int PROD_W     = Q16_W + FRAC_W;
    localparam int DOWN_SHIFT = 16 - FRAC_BITS;
    localparam int HP_W       = 2 * ACT_W;
    localparam int ACC_W      = ACT_W + DATA_W + 1;

    localparam int GATE_ONE = 1 << FRAC_BITS;
    localparam int CELL_MAX = 32767;
    localparam int CELL_MIN = -32768;
    localparam int HID_MAX  = 8191;
    localparam int HID_MIN  = -8192;

    localparam int NSTAGE = 11;

    localparam int TBL_N  = 33;
    localparam int TBL_IW = $clog2(TBL_N);

    localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);

    localparam logic [Q16_W-1:0] TANH_TBL [TBL_N] = '{
        17'd0,     17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593,
        17'd59320, 17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65003,
        17'd65212, 17'd65339, 17'd65417, 17'd65464, 17'd65492, 17'd65509,
        17'd65520, 17'd65526, 17'd65530, 17'd65532, 17'd65534, 17'd65535,
        17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536
    };

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } t_act_ctl;

endpackage

// ===== sv/lcf_if.sv =====
// Valid/ready channel interfaces for the cell update input and result.
interface lcf_in_if
    import lcf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [IDX_W-1:0]  cell_index;
    logic signed [DATA_W-1:0] hidden_forget_pre;
    logic signed [DATA_W-1:0] hidden_input_pre;
    logic signed [DATA_W-1:0] hidden_cand_pre;
    logic signed [DATA_W-1:0] hidden_outgate_pre;
    logic signed [DATA_W-1:0] input_forget_pre;
    logic signed [DATA_W-1:0] input_input_pre;
    logic signed [DATA_W-1:0] input_cand_pre;
    logic signed [DATA_W-1:0] input_outgate_pre;

    modport source (
        output valid, cell_index,
        output hidden_forget_pre, hidden_input_pre, hidden_cand_pre, hidden_outgate_pre,
        output input_forget_pre, input_input_pre, input_cand_pre, input_outgate_pre,
        input  ready
    );
    modport sink (
        input  valid, cell_index,
        input  hidden_forget_pre, hidden_input_pre, hidden_cand_pre, hidden_outgate_pre,
        input  input_forget_pre, input_input_pre, input_cand_pre, input_outgate_pre,
        output ready
    );
endinterface

interface lcf_out_if
    import lcf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cell_out;
    logic signed [HID_W-1:0]  hidden_out;

    modport source (output valid, cell_out, hidden_out, input ready);
    modport sink   (input valid, cell_out, hidden_out, output ready);
endinterface

// ===== sv/lcf_act.sv =====
// Three-stage tanh / logistic unit: table lookup, interpolation product, finish.
module lcf_act
    import lcf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_logistic,
    input  t_act_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_x,
    output logic signed [ACT_W-1:0]  o_y
);

    logic signed [MAG_W-1:0] w_xe;
    logic        [MAG_W-1:0] w_mag;
    logic        [MAG_W-1:0] w_tidx;
    logic        [FRAC_W-1:0] w_frac;
    logic                    w_sat;
    logic        [TBL_IW-1:0] w_k;
    logic        [TBL_IW-1:0] w_k1;
    logic        [Q16_W-1:0] w_lo;
    logic        [Q16_W-1:0] w_hi;

    logic                    r_a_neg;
    logic        [Q16_W-1:0] r_a_lo;
    logic        [Q16_W-1:0] r_a_diff;
    logic        [FRAC_W-1:0] r_a_frac;

    logic                    r_b_neg;
    logic        [Q16_W-1:0] r_b_lo;
    logic        [PROD_W-1:0] r_b_prod;

    logic        [Q16_W-1:0] w_t;
    logic        [S_W-1:0]   w_s;
    logic        [Q16_W-1:0] w_q;
    logic        [Q16_W-1:0] w_qr;
    logic signed [ACT_W-1:0] w_r;
    logic signed [ACT_W-1:0] n_y;

    always_comb begin
        w_xe  = MAG_W'(i_x);
        w_mag = i_x[DATA_W-1] ? MAG_W'(-w_xe) : MAG_W'(w_xe);
        if (i_logistic) begin
            w_tidx = w_mag >> LOG_SHIFT;
            w_frac = FRAC_W'(w_mag);
        end else begin
            w_tidx = w_mag >> TANH_SHIFT;
            w_frac = FRAC_W'(w_mag & ((MAG_W'(1) << TANH_SHIFT) - MAG_W'(1)));
        end
        w_sat = w_tidx >= MAG_W'(TBL_N - 1);
        w_k   = w_sat ? TBL_IW'(TBL_N - 1) : TBL_IW'(w_tidx);
        w_k1  = w_sat ? w_k : w_k + TBL_IW'(1);
        w_lo  = TANH_TBL[w_k];
        w_hi  = TANH_TBL[w_k1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_a_neg  <= i_x[DATA_W-1];
            r_a_lo   <= w_lo;
            r_a_diff <= w_hi - w_lo;
            r_a_frac <= w_frac;
        end
        if (i_ctl.en_b) begin
            r_b_neg  <= r_a_neg;
            r_b_lo   <= r_a_lo;
            r_b_prod <= PROD_W'(r_a_diff) * PROD_W'(r_a_frac);
        end
        if (i_ctl.en_c) begin
            o_y <= n_y;
        end
    end

    always_comb begin
        w_t  = r_b_lo + Q16_W'(r_b_prod >> (i_logistic ? LOG_SHIFT : TANH_SHIFT));
        w_s  = r_b_neg ? (S_W'(Q16_ONE) - S_W'(w_t)) >> 1 : (S_W'(Q16_ONE) + S_W'(w_t)) >> 1;
        w_q  = i_logistic ? Q16_W'(w_s) : w_t;
        w_qr = w_q + Q16_W'(1 << (DOWN_SHIFT - 1));
        w_r  = ACT_W'(w_qr >> DOWN_SHIFT);
        n_y  = (r_b_neg && !i_logistic) ? -w_r : w_r;
    end

endmodule

// ===== sv/lstm_cell_forward_core.sv =====
// Top level: pipelined element-wise LSTM cell update with on-chip cell store.
//
//  channel  | dir | payload                                    | accept
//  i_in     | in  | cell_index, 8 gate pre-activations (Q3.12) | valid & ready
//  o_out    | out | cell_out (Q3.12), hidden_out (Q1.12)       | valid & ready
//
//  One transaction per cycle sustained while o_out is ready. The f*c + i*g
//  update and its store forwarding close in one stage. Reset clears the pipeline
//  valid bits and the per-entry store valid bits at once; no clearing pass. A stall
//  on o_out holds full stages while bubbles ahead of it close up, so input keeps
//  flowing until the pipeline is full.
`include "assert_macros.svh"

module lstm_cell_forward_core
    import lcf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    lcf_in_if.sink  i_in,
    lcf_out_if.source o_out
);

    function automatic logic signed [DATA_W-1:0] sat_sum(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
        if (s > CELL_MAX) begin
            return DATA_W'(CELL_MAX);
        end else if (s < CELL_MIN) begin
            return DATA_W'(CELL_MIN);
        end
        return DATA_W'(s);
    endfunction

    logic [NSTAGE:1] r_vld;
    logic [NSTAGE:1] w_rdy;

    logic        [IDX_W-1:0]  r_s1_idx;
    logic signed [DATA_W-1:0] r_s1_f;
    logic signed [DATA_W-1:0] r_s1_i;
    logic signed [DATA_W-1:0] r_s1_g;
    logic signed [DATA_W-1:0] r_s1_o;
    logic        [IDX_W-1:0]  r_s2_idx;
    logic        [IDX_W-1:0]  r_s3_idx;
    logic        [IDX_W-1:0]  r_s4_idx;

    logic signed [ACT_W-1:0] w_f;
    logic signed [ACT_W-1:0] w_i;
    logic signed [ACT_W-1:0] w_g;
    logic signed [ACT_W-1:0] w_o;
    t_act_ctl                w_gate_ctl;
    t_act_ctl                w_cell_ctl;

    logic        [IDX_W-1:0]  r_s5_idx;
    logic signed [ACT_W-1:0]  r_s5_f;
    logic signed [ACT_W-1:0]  r_s5_o;
    logic signed [HP_W-1:0]   r_s5_ig;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_rd_vld;

    logic signed [DATA_W-1:0] r_cell_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0]    r_cell_vld;
    logic [CELL_AW-1:0]       w_rd_addr;
    logic [CELL_AW-1:0]       w_wr_addr;
    logic                     w_s5_inr;
    logic                     w_wr_en;
    logic signed [DATA_W-1:0] w_c_old;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_c_rnd;
    logic signed [DATA_W-1:0] n_s6_cell;

    logic        [IDX_W-1:0]  r_s6_idx;
    logic                     r_s6_wr;
    logic signed [DATA_W-1:0] r_s6_cell;
    logic signed [ACT_W-1:0]  r_s6_o;
    logic signed [DATA_W-1:0] r_s7_cell;
    logic signed [ACT_W-1:0]  r_s7_o;
    logic signed [DATA_W-1:0] r_s8_cell;
    logic signed [ACT_W-1:0]  r_s8_o;
    logic signed [DATA_W-1:0] r_s9_cell;
    logic signed [ACT_W-1:0]  r_s9_o;
    logic signed [ACT_W-1:0]  w_tc;

    logic signed [DATA_W-1:0] r_s10_cell;
    logic signed [HP_W-1:0]   r_s10_prod;
    logic signed [HP_W-1:0]   w_h_rnd;
    logic signed [HID_W-1:0]  n_s11_hid;
    logic signed [DATA_W-1:0] r_s11_cell;
    logic signed [HID_W-1:0]  r_s11_hid;

    // stage handshake: a stage loads when empty or when the one after it moves
    always_comb begin
        w_rdy[NSTAGE] = !r_vld[NSTAGE] || o_out.ready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_rdy[1];
    assign o_out.valid = r_vld[NSTAGE];
    assign o_out.cell_out   = r_s11_cell;
    assign o_out.hidden_out = r_s11_hid;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_idx <= i_in.cell_index;
            r_s1_f   <= sat_sum(i_in.hidden_forget_pre, i_in.input_forget_pre);
            r_s1_i   <= sat_sum(i_in.hidden_input_pre, i_in.input_input_pre);
            r_s1_g   <= sat_sum(i_in.hidden_cand_pre, i_in.input_cand_pre);
            r_s1_o   <= sat_sum(i_in.hidden_outgate_pre, i_in.input_outgate_pre);
        end
        if (w_rdy[2]) begin
            r_s2_idx <= r_s1_idx;
        end
        if (w_rdy[3]) begin
            r_s3_idx <= r_s2_idx;
        end
        if (w_rdy[4]) begin
            r_s4_idx <= r_s3_idx;
        end
    end

    assign w_gate_ctl = '{en_a: w_rdy[2], en_b: w_rdy[3], en_c: w_rdy[4]};
    assign w_cell_ctl = '{en_a: w_rdy[7], en_b: w_rdy[8], en_c: w_rdy[9]};

    lcf_act u_act_f (
        .i_clk(i_clk), .i_logistic(1'b1), .i_ctl(w_gate_ctl), .i_x(r_s1_f), .o_y(w_f)
    );
    lcf_act u_act_i (
        .i_clk(i_clk), .i_logistic(1'b1), .i_ctl(w_gate_ctl), .i_x(r_s1_i), .o_y(w_i)
    );
    lcf_act u_act_g (
        .i_clk(i_clk), .i_logistic(1'b0), .i_ctl(w_gate_ctl), .i_x(r_s1_g), .o_y(w_g)
    );
    lcf_act u_act_o (
        .i_clk(i_clk), .i_logistic(1'b1), .i_ctl(w_gate_ctl), .i_x(r_s1_o), .o_y(w_o)
    );

    assign w_rd_addr = CELL_AW'(r_s4_idx);
    assign w_wr_addr = CELL_AW'(r_s5_idx);
    assign w_s5_inr  = int'(r_s5_idx) < CELL_COUNT;
    assign w_wr_en   = r_vld[5] && w_rdy[6] && w_s5_inr;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s5_idx  <= r_s4_idx;
            r_s5_f    <= w_f;
            r_s5_o    <= w_o;
            r_s5_ig   <= HP_W'(w_i) * HP_W'(w_g);
            r_rd_data <= r_cell_mem[w_rd_addr];
            r_rd_vld  <= r_cell_vld[w_rd_addr];
        end
        if (w_wr_en) begin
            r_cell_mem[w_wr_addr] <= n_s6_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld <= '0;
        end else if (w_wr_en) begin
            r_cell_vld[w_wr_addr] <= 1'b1;
        end
    end

    // forward the previous transaction's cell when it hits the same entry
    always_comb begin
        if (!w_s5_inr) begin
            w_c_old = '0;
        end else if (r_vld[6] && r_s6_wr && r_s6_idx == r_s5_idx) begin
            w_c_old = r_s6_cell;
        end else if (r_rd_vld) begin
            w_c_old = r_rd_data;
        end else begin
            w_c_old = '0;
        end
        w_acc   = ACC_W'(r_s5_f) * ACC_W'(w_c_old) + ACC_W'(r_s5_ig);
        w_c_rnd = (w_acc + ACC_W'(GATE_ONE >> 1)) >>> FRAC_BITS;
        if (w_c_rnd > CELL_MAX) begin
            n_s6_cell = DATA_W'(CELL_MAX);
        end else if (w_c_rnd < CELL_MIN) begin
            n_s6_cell = DATA_W'(CELL_MIN);
        end else begin
            n_s6_cell = DATA_W'(w_c_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s6_idx  <= r_s5_idx;
            r_s6_wr   <= w_s5_inr;
            r_s6_cell <= n_s6_cell;
            r_s6_o    <= r_s5_o;
        end
        if (w_rdy[7]) begin
            r_s7_cell <= r_s6_cell;
            r_s7_o    <= r_s6_o;
        end
        if (w_rdy[8]) begin
            r_s8_cell <= r_s7_cell;
            r_s8_o    <= r_s7_o;
        end
        if (w_rdy[9]) begin
            r_s9_cell <= r_s8_cell;
            r_s9_o    <= r_s8_o;
        end
        if (w_rdy[10]) begin
            r_s10_cell <= r_s9_cell;
            r_s10_prod <= HP_W'(r_s9_o) * HP_W'(w_tc);
        end
        if (w_rdy[11]) begin
            r_s11_cell <= r_s10_cell;
            r_s11_hid  <= n_s11_hid;
        end
    end

    lcf_act u_act_c (
        .i_clk(i_clk), .i_logistic(1'b0), .i_ctl(w_cell_ctl), .i_x(r_s6_cell), .o_y(w_tc)
    );

    always_comb begin
        w_h_rnd = (r_s10_prod + HP_W'(GATE_ONE >> 1)) >>> FRAC_BITS;
        if (w_h_rnd > HID_MAX) begin
            n_s11_hid = HID_W'(HID_MAX);
        end else if (w_h_rnd < HID_MIN) begin
            n_s11_hid = HID_W'(HID_MIN);
        end else begin
            n_s11_hid = HID_W'(w_h_rnd);
        end
    end

    `ASSERT_CLK(a_store_mark, w_wr_en |=> r_cell_vld[$past(w_wr_addr)], "store write left entry unmarked")
    `ASSERT_CLK(a_gate_range, r_vld[4] |-> (w_f >= 0 && w_f <= GATE_ONE), "forget gate out of range")
    `ASSERT_CLK(a_hid_range, o_out.valid |-> (o_out.hidden_out <= GATE_ONE && o_out.hidden_out >= -GATE_ONE), "hidden out of range")
    `ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out.valid, "output valid right after reset")

endmodule
